FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Types and codes shared by the cuckoo table with stash.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int WORD_W = 64;
  localparam int KEY_W  = 128;
  localparam int MOD_W  = 13;
  localparam int HNUM_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_DROP = 2'd2;

  localparam logic [1:0] CFG_NUM_HASHES   = 2'd0;
  localparam logic [1:0] CFG_BINS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_STASH_IN_USE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_KEY_RD,
    S_DIV_GO,
    S_DIV,
    S_BIN_RD,
    S_BIN,
    S_F_KEY,
    S_F_STASH,
    S_F_SKEY,
    S_STASH
  } state_t;

endpackage

FILE: rtl/core/chs_modu.sv
// ----------------------------------------------------------------------------
// chs_modu
// Bit-serial remainder unit: 64-bit word modulo a 13-bit divisor.
// ----------------------------------------------------------------------------
module chs_modu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [chs_pkg::WORD_W-1:0]  dividend,
  input  logic [chs_pkg::MOD_W-1:0]   divisor,
  output logic                        done,
  output logic [chs_pkg::MOD_W-1:0]   rem
);

  localparam int CW = $clog2(chs_pkg::WORD_W);

  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [chs_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [chs_pkg::MOD_W-1:0]  rem_r, rem_nxt;
  logic [chs_pkg::MOD_W:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, word_r[chs_pkg::WORD_W-1]};
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      word_nxt = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      // one restoring step per cycle
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = chs_pkg::MOD_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = chs_pkg::MOD_W'(trial);
      end
      word_nxt = {word_r[chs_pkg::WORD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(chs_pkg::WORD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/core/cuckoo_hash_table_with_stash.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table_with_stash
// Cuckoo hash table of item indexes with a small overflow stash.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request (insert or find) is taken when start is high
//   and busy is low. busy stays high until the request's result is out.
//   Result channel: out_valid strobes for one cycle with out_status and
//   out_found_index; the receiver cannot stall, so the result is never held.
//   Config channel: cfg_ready is always high; a write lands when cfg_valid is
//   high. Write only while busy is low. Unknown indexes are ignored.
// Sequencing:
//   Every hash goes through one shared bit-serial remainder unit of 64 steps;
//   the remainder is seen when the unit raises done.
//   A placement step runs key read, remainder start, remainder, bin read and
//   bin write. An insert first reduces and latches the index, then runs up to
//   MAX_TRIES placements, then visits stash slots one by one, with one more
//   step when the item is dropped. A find probes each hash by remainder start,
//   remainder, bin read and bin check, plus a key compare when the bin holds
//   an entry, then compares stash slots and finishes. Index reduction
//   subtracts ITEMS repeatedly. The result strobes the cycle busy drops.
// Reset:
//   After reset the block sweeps the bin memory clear, one bin per cycle,
//   all BINS bins, with busy high. Config writes are taken during the sweep.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_with_stash #(
  parameter int ITEMS       = 1024,
  parameter int BINS        = 4096,
  parameter int STASH_DEPTH = 8,
  parameter int MAX_TRIES   = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [9:0]  in_item_index,
  input  logic [63:0] in_key_low,
  input  logic [63:0] in_key_high,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [9:0]  out_found_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int IXW = $clog2(ITEMS);
  localparam int IRW = (IXW > 10) ? IXW : 10;
  localparam int AW  = $clog2(BINS);
  localparam int SIW = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
  localparam int SJW = $clog2(STASH_DEPTH + 1);
  localparam int TW  = $clog2(MAX_TRIES + 1);

  typedef struct packed {
    logic                            valid;
    logic [IXW-1:0]                  idx;
    logic [chs_pkg::HNUM_W-1:0]      hnum;
  } entry_t;

  function automatic logic [3:0] mod_small(input logic [3:0] v, input logic [3:0] m);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

  // config registers
  logic [3:0]  cfg_k_r;
  logic [12:0] cfg_bins_r;
  logic [3:0]  cfg_stash_r;

  // sequencer and request context
  chs_pkg::state_t               state_r, state_nxt;
  logic                          op_r, op_nxt;
  logic [chs_pkg::KEY_W-1:0]     qkey_r, qkey_nxt;
  logic [IRW-1:0]                idx_r, idx_nxt;
  entry_t                        held_r, held_nxt;
  logic [chs_pkg::HNUM_W-1:0]    h_r, h_nxt;
  logic [TW-1:0]                 tries_r, tries_nxt;
  logic [SJW-1:0]                sj_r, sj_nxt;
  logic [IXW-1:0]                cand_r, cand_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [9:0]                    out_found_r, out_found_nxt;

  // storage
  entry_t                        bin_mem [BINS];
  entry_t                        bin_rd_r;
  logic                          bin_we;
  logic [AW-1:0]                 bin_waddr;
  entry_t                        bin_wdata;
  logic [AW-1:0]                 bin_addr;

  logic [chs_pkg::KEY_W-1:0]     key_mem [ITEMS];
  logic [chs_pkg::KEY_W-1:0]     key_rd_r;
  logic                          key_we;
  logic [IXW-1:0]                key_raddr;

  entry_t                        stash_r [STASH_DEPTH];
  logic                          stash_we;
  logic [SIW-1:0]                sidx;

  // effective config
  logic [3:0]                    k_eff;
  logic [chs_pkg::MOD_W-1:0]     bins_eff;
  logic [SJW-1:0]                ns_eff;

  // remainder unit hookup
  logic                          div_start;
  logic                          div_done;
  logic [chs_pkg::MOD_W-1:0]     div_rem;
  logic [chs_pkg::KEY_W-1:0]     key_src;
  logic [chs_pkg::HNUM_W-1:0]    hsel;
  logic [chs_pkg::WORD_W-1:0]    div_word;
  logic                          key_hit;

  always_comb begin
    if (cfg_k_r < 4'd2)      k_eff = 4'd2;
    else if (cfg_k_r > 4'd8) k_eff = 4'd8;
    else                     k_eff = cfg_k_r;
  end

  always_comb begin
    if (cfg_bins_r == '0)                bins_eff = chs_pkg::MOD_W'(1);
    else if (32'(cfg_bins_r) > BINS)     bins_eff = chs_pkg::MOD_W'(BINS);
    else                                 bins_eff = cfg_bins_r;
  end

  always_comb begin
    if (32'(cfg_stash_r) > STASH_DEPTH) ns_eff = SJW'(STASH_DEPTH);
    else                                ns_eff = SJW'(cfg_stash_r);
  end

  // hash word: 8 bytes starting at byte offset h of the key
  assign key_src  = (op_r == chs_pkg::OP_FIND) ? qkey_r : key_rd_r;
  assign hsel     = (op_r == chs_pkg::OP_FIND) ? h_r : held_r.hnum;
  assign div_word = chs_pkg::WORD_W'(key_src >> {hsel, 3'b000});
  assign bin_addr = AW'(div_rem);
  assign key_hit  = (key_rd_r == qkey_r);
  assign sidx     = sj_r[SIW-1:0];

  chs_modu u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_word),
    .divisor  (bins_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    qkey_nxt       = qkey_r;
    idx_nxt        = idx_r;
    held_nxt       = held_r;
    h_nxt          = h_r;
    tries_nxt      = tries_r;
    sj_nxt         = sj_r;
    cand_nxt       = cand_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    bin_we         = 1'b0;
    bin_waddr      = bin_addr;
    bin_wdata      = held_r;
    key_we         = 1'b0;
    key_raddr      = held_r.idx;
    stash_we       = 1'b0;
    div_start      = 1'b0;

    unique case (state_r)
      chs_pkg::S_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_r;
        bin_wdata = '0;
        if (clr_r == AW'(BINS - 1)) begin
          state_nxt = chs_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      chs_pkg::S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          qkey_nxt  = {in_key_high, in_key_low};
          idx_nxt   = IRW'(in_item_index);
          h_nxt     = '0;
          sj_nxt    = '0;
          tries_nxt = '0;
          state_nxt = (in_operation == chs_pkg::OP_FIND) ? chs_pkg::S_DIV_GO
                                                         : chs_pkg::S_REDUCE;
        end
      end
      chs_pkg::S_REDUCE: begin
        // index modulo ITEMS by repeated subtraction
        if (32'(idx_r) >= ITEMS) begin
          idx_nxt = idx_r - IRW'(ITEMS);
        end else begin
          key_we    = 1'b1;
          held_nxt  = '{valid: 1'b1, idx: IXW'(idx_r), hnum: '0};
          state_nxt = chs_pkg::S_KEY_RD;
        end
      end
      chs_pkg::S_KEY_RD: begin
        key_raddr = held_r.idx;
        state_nxt = chs_pkg::S_DIV_GO;
      end
      chs_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = chs_pkg::S_DIV;
      end
      chs_pkg::S_DIV: begin
        if (div_done) state_nxt = chs_pkg::S_BIN_RD;
      end
      chs_pkg::S_BIN_RD: begin
        state_nxt = chs_pkg::S_BIN;
      end
      chs_pkg::S_BIN: begin
        if (op_r == chs_pkg::OP_INSERT) begin
          // place held item, evicted occupant becomes held
          bin_we   = 1'b1;
          held_nxt = bin_rd_r;
          if (bin_rd_r.valid) begin
            held_nxt.hnum = chs_pkg::HNUM_W'(mod_small({1'b0, bin_rd_r.hnum} + 4'd1, k_eff));
          end
          if (!bin_rd_r.valid) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = chs_pkg::STAT_OK;
            out_found_nxt  = '0;
            state_nxt      = chs_pkg::S_IDLE;
          end else if (tries_r == TW'(MAX_TRIES - 1)) begin
            sj_nxt    = '0;
            state_nxt = chs_pkg::S_STASH;
          end else begin
            tries_nxt = tries_r + 1'b1;
            state_nxt = chs_pkg::S_KEY_RD;
          end
        end else if (bin_rd_r.valid) begin
          key_raddr = bin_rd_r.idx;
          cand_nxt  = bin_rd_r.idx;
          state_nxt = chs_pkg::S_F_KEY;
        end else if ({1'b0, h_r} + 4'd1 < k_eff) begin
          h_nxt     = h_r + 1'b1;
          state_nxt = chs_pkg::S_DIV_GO;
        end else begin
          state_nxt = chs_pkg::S_F_STASH;
        end
      end
      chs_pkg::S_F_KEY: begin
        if (key_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = chs_pkg::STAT_OK;
          out_found_nxt  = 10'(cand_r);
          state_nxt      = chs_pkg::S_IDLE;
        end else if ({1'b0, h_r} + 4'd1 < k_eff) begin
          h_nxt     = h_r + 1'b1;
          state_nxt = chs_pkg::S_DIV_GO;
        end else begin
          state_nxt = chs_pkg::S_F_STASH;
        end
      end
      chs_pkg::S_F_STASH: begin
        // scan stops at the first empty slot
        if (sj_r < ns_eff && stash_r[sidx].valid) begin
          key_raddr = stash_r[sidx].idx;
          cand_nxt  = stash_r[sidx].idx;
          state_nxt = chs_pkg::S_F_SKEY;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = chs_pkg::STAT_MISS;
          out_found_nxt  = '0;
          state_nxt      = chs_pkg::S_IDLE;
        end
      end
      chs_pkg::S_F_SKEY: begin
        if (key_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = chs_pkg::STAT_OK;
          out_found_nxt  = 10'(cand_r);
          state_nxt      = chs_pkg::S_IDLE;
        end else begin
          sj_nxt    = sj_r + 1'b1;
          state_nxt = chs_pkg::S_F_STASH;
        end
      end
      chs_pkg::S_STASH: begin
        // shift-swap into the stash until an empty slot takes the held item; drop it when the stash in use is full
        if (sj_r >= ns_eff) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = chs_pkg::STAT_DROP;
          out_found_nxt  = '0;
          state_nxt      = chs_pkg::S_IDLE;
        end else begin
          stash_we = 1'b1;
          held_nxt = stash_r[sidx];
          if (!stash_r[sidx].valid) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = chs_pkg::STAT_OK;
            out_found_nxt  = '0;
            state_nxt      = chs_pkg::S_IDLE;
          end else begin
            sj_nxt = sj_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = chs_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= chs_pkg::S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= chs_pkg::STAT_OK;
      out_found_r  <= '0;
      cfg_k_r      <= 4'd2;
      cfg_bins_r   <= 13'd4096;
      cfg_stash_r  <= 4'd4;
      stash_r      <= '{default: '0};
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_found_r  <= out_found_nxt;
      if (stash_we) stash_r[sidx] <= held_r;
      if (cfg_valid) begin
        unique case (cfg_index)
          chs_pkg::CFG_NUM_HASHES:   cfg_k_r     <= cfg_data[3:0];
          chs_pkg::CFG_BINS_IN_USE:  cfg_bins_r  <= cfg_data;
          chs_pkg::CFG_STASH_IN_USE: cfg_stash_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // request context
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    qkey_r  <= qkey_nxt;
    idx_r   <= idx_nxt;
    held_r  <= held_nxt;
    h_r     <= h_nxt;
    tries_r <= tries_nxt;
    sj_r    <= sj_nxt;
    cand_r  <= cand_nxt;
  end

  // bin memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    bin_rd_r <= bin_mem[bin_addr];
  end

  // key store
  always_ff @(posedge clk) begin
    if (key_we) key_mem[IXW'(idx_r)] <= qkey_r;
    key_rd_r <= key_mem[key_raddr];
  end

  assign busy            = (state_r != chs_pkg::S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;

endmodule

FILE: rtl/core/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks on the request/result behavior of the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [9:0] out_found_index
);

  logic status_legal;
  logic res_not_ok;

  assign status_legal = (out_status == chs_pkg::STAT_OK) ||
                        (out_status == chs_pkg::STAT_MISS) ||
                        (out_status == chs_pkg::STAT_DROP);
  assign res_not_ok   = out_valid && (out_status != chs_pkg::STAT_OK);

  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMP(a_result_from_busy, clk, rst_n, out_valid, $past(busy))
  `ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, status_legal)
  `ASSERT_IMP(a_miss_zero_idx, clk, rst_n, res_not_ok, out_found_index == 10'd0)

endmodule

bind cuckoo_hash_table_with_stash chs_checker u_chs_checker (.*);
